// File: rtl/att_pkg.sv
// ----------------------------------------------------------------------------
// att_pkg
// Types, widths and constants shared by the attitude pipeline.
// ----------------------------------------------------------------------------
package att_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TAB_LEN          = 24;

	// atan(2^-i) in units of 1/256 centidegree
	localparam int ATAN_TAB [TAB_LEN] = '{
		1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
		5730, 2865, 1432, 716, 358, 179, 90, 45,
		22, 11, 6, 3, 1, 1, 0, 0
	};

	localparam int RAD_W  = 48;   // (ay^2 + az^2) * 2^16
	localparam int ROOT_W = 24;
	localparam int REM_W  = 27;
	localparam int CIN_W  = 25;   // CORDIC operand, raw counts * 2^8
	localparam int XY_W   = 36;   // CORDIC x/y, operand * 2^8 plus gain
	localparam int ACC_W  = 24;   // angle accumulator, 1/256 centidegree
	localparam int ANG_W  = 16;

	localparam logic signed [15:0] DECL_RESET = -16'sd400;
	localparam int HALF_TURN    = 18000;
	localparam int QUARTER_TURN = 9000;
	localparam int FULL_TURN    = 36000;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] mag_first;
		logic signed [15:0] mag_second;
	} sample_t;

	typedef struct packed {
		logic signed [14:0] pitch_centideg;
		logic signed [15:0] roll_centideg;
		logic        [15:0] heading_centideg;
	} attitude_t;

	// raw 16-bit count scaled by 2^8 into a CORDIC operand
	function automatic logic signed [CIN_W-1:0] scale8(input logic signed [15:0] v);
		scale8 = $signed({{(CIN_W-24){v[15]}}, v, 8'b0});
	endfunction

endpackage

// File: rtl/att_isqrt.sv
// ----------------------------------------------------------------------------
// att_isqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module att_isqrt import att_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [RAD_W-1:0]  radicand,
	input  sample_t           side_in,
	output logic              out_valid,
	output logic [ROOT_W-1:0] root,
	output sample_t           side_out
);

	logic              vld_sk  [ROOT_W];
	logic [REM_W-1:0]  rem_sk  [ROOT_W];
	logic [ROOT_W-1:0] root_sk [ROOT_W];
	logic [RAD_W-1:0]  rad_sk  [ROOT_W];
	sample_t           side_sk [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		logic              vld_in;
		logic [REM_W-1:0]  rem_in, rem_sh, trial;
		logic [ROOT_W-1:0] root_in;
		logic [RAD_W-1:0]  rad_in;
		sample_t           side_in_k;
		logic              ge;

		if (k == 0) begin : g_first
			assign vld_in    = in_valid;
			assign rem_in    = '0;
			assign root_in   = '0;
			assign rad_in    = radicand;
			assign side_in_k = side_in;
		end else begin : g_next
			assign vld_in    = vld_sk[k-1];
			assign rem_in    = rem_sk[k-1];
			assign root_in   = root_sk[k-1];
			assign rad_in    = rad_sk[k-1];
			assign side_in_k = side_sk[k-1];
		end

		assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
		assign trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_in, 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k] <= 1'b0;
			end else if (en) begin
				vld_sk[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[k]  <= ge ? (rem_sh - trial) : rem_sh;
				root_sk[k] <= {root_in[ROOT_W-2:0], ge};
				rad_sk[k]  <= {rad_in[RAD_W-3:0], 2'b00};
				side_sk[k] <= side_in_k;
			end
		end
	end

	assign out_valid = vld_sk[ROOT_W-1];
	assign root      = root_sk[ROOT_W-1];
	assign side_out  = side_sk[ROOT_W-1];

endmodule

// File: rtl/att_cordic.sv
// ----------------------------------------------------------------------------
// att_cordic
// Pipelined vectoring CORDIC: atan2(num, den) in centidegrees; heading_rule changes the zero-den case.
// ----------------------------------------------------------------------------
module att_cordic import att_pkg::*; #(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [CIN_W-1:0] num,
	input  logic signed [CIN_W-1:0] den,
	input  logic                    heading_rule,
	output logic                    out_valid,
	output logic signed [ANG_W-1:0] angle
);

	localparam logic signed [ANG_W-1:0] HALF    = ANG_W'(HALF_TURN);
	localparam logic signed [ANG_W-1:0] QUARTER = ANG_W'(QUARTER_TURN);
	localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(HALF_TURN * 256);

	// ---- entry stage: special cases and half-plane fold
	logic                    vld_s1, spc_s1;
	logic signed [ANG_W-1:0] spv_s1;
	logic signed [XY_W-1:0]  x_s1, y_s1;
	logic signed [ACC_W-1:0] acc_s1;

	logic signed [XY_W-1:0]  x_pre, y_pre;
	logic                    num_zero, den_zero, den_neg;
	logic signed [ANG_W-1:0] spv_pre;

	assign x_pre    = $signed({{(XY_W-CIN_W-8){den[CIN_W-1]}}, den, 8'b0});
	assign y_pre    = $signed({{(XY_W-CIN_W-8){num[CIN_W-1]}}, num, 8'b0});
	assign num_zero = (num == '0);
	assign den_zero = (den == '0);
	assign den_neg  = den[CIN_W-1];

	always_comb begin
		if (num_zero) begin
			spv_pre = den_neg ? HALF : '0;
		end else if (heading_rule) begin
			spv_pre = num[CIN_W-1] ? HALF : '0;
		end else begin
			spv_pre = num[CIN_W-1] ? -QUARTER : QUARTER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spc_s1 <= num_zero | den_zero;
			spv_s1 <= spv_pre;
			x_s1   <= den_neg ? -x_pre : x_pre;
			y_s1   <= den_neg ? -y_pre : y_pre;
			if (den_neg) begin
				acc_s1 <= num[CIN_W-1] ? -HALF_ACC : HALF_ACC;
			end else begin
				acc_s1 <= '0;
			end
		end
	end

	// ---- micro-rotations, one per stage
	logic                    vld_sk [STEPS];
	logic                    spc_sk [STEPS];
	logic signed [ANG_W-1:0] spv_sk [STEPS];
	logic signed [XY_W-1:0]  x_sk   [STEPS];
	logic signed [XY_W-1:0]  y_sk   [STEPS];
	logic signed [ACC_W-1:0] acc_sk [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_rot
		logic                    vld_in, spc_in;
		logic signed [ANG_W-1:0] spv_in;
		logic signed [XY_W-1:0]  x_in, y_in, dx, dy;
		logic signed [ACC_W-1:0] acc_in, ang;

		if (k == 0) begin : g_first
			assign vld_in = vld_s1;
			assign spc_in = spc_s1;
			assign spv_in = spv_s1;
			assign x_in   = x_s1;
			assign y_in   = y_s1;
			assign acc_in = acc_s1;
		end else begin : g_next
			assign vld_in = vld_sk[k-1];
			assign spc_in = spc_sk[k-1];
			assign spv_in = spv_sk[k-1];
			assign x_in   = x_sk[k-1];
			assign y_in   = y_sk[k-1];
			assign acc_in = acc_sk[k-1];
		end

		assign dx  = y_in >>> k;
		assign dy  = x_in >>> k;
		assign ang = ACC_W'(ATAN_TAB[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k] <= 1'b0;
			end else if (en) begin
				vld_sk[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				spc_sk[k] <= spc_in;
				spv_sk[k] <= spv_in;
				if (!y_in[XY_W-1]) begin
					x_sk[k]   <= x_in + dx;
					y_sk[k]   <= y_in - dy;
					acc_sk[k] <= acc_in + ang;
				end else begin
					x_sk[k]   <= x_in - dx;
					y_sk[k]   <= y_in + dy;
					acc_sk[k] <= acc_in - ang;
				end
			end
		end
	end

	// ---- rounding and saturation
	logic signed [ACC_W-1:0] acc_rnd;
	logic signed [ANG_W-1:0] r_cd;
	logic                    vld_s3;
	logic signed [ANG_W-1:0] angle_s3;

	assign acc_rnd = acc_sk[STEPS-1] + ACC_W'(128);
	assign r_cd    = acc_rnd[ACC_W-1:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_sk[STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (spc_sk[STEPS-1]) begin
				angle_s3 <= spv_sk[STEPS-1];
			end else if (r_cd > HALF) begin
				angle_s3 <= HALF;
			end else if (r_cd < -HALF) begin
				angle_s3 <= -HALF;
			end else begin
				angle_s3 <= r_cd;
			end
		end
	end

	assign out_valid = vld_s3;
	assign angle     = angle_s3;

endmodule

// File: rtl/attitude_from_accel_mag.sv
// ----------------------------------------------------------------------------
// attitude_from_accel_mag
// Roll, pitch and declination-corrected heading from one accel/mag sample.
// ----------------------------------------------------------------------------
// Input channel sample_valid/sample_ready carries one sample_t item: three
// accelerometer axes and two magnetometer components. Output channel
// attitude_valid/attitude_ready carries one attitude_t item per sample, in
// centidegrees. cfg_valid/cfg_ready/cfg_data writes the declination; write it
// only while no item is in flight. Reset loads -4.00 degrees.
// Stages in order: a square register and a sum register, 24 square-root
// stages (one root bit each), one CORDIC entry stage, CORDIC_STEPS rotation
// stages, one rounding stage and the output register. One item is accepted
// every cycle while the output is not stalled.
// All stages share one enable: while an item waits at the output and the
// receiver holds attitude_ready low, the whole pipeline and sample_ready
// stall, so nothing is lost or repeated. Reset clears every valid bit.
// ----------------------------------------------------------------------------
module attitude_from_accel_mag import att_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  sample_t            sample,
	output logic               attitude_valid,
	input  logic               attitude_ready,
	output attitude_t          attitude,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic signed [15:0] cfg_data
);

	logic               en;
	logic signed [15:0] decl_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q <= DECL_RESET;
		end else if (cfg_valid) begin
			decl_q <= cfg_data;
		end
	end

	logic out_vld_q;
	assign en           = !out_vld_q || attitude_ready;
	assign sample_ready = en;

	// ---- squares and sum for the pitch denominator
	logic signed [31:0] py, pz;
	logic               vld_s1, vld_s2;
	logic [31:0]        sq_y_s1, sq_z_s1, sum_s2;
	sample_t            item_s1, item_s2;

	assign py = sample.accel_y * sample.accel_y;
	assign pz = sample.accel_z * sample.accel_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sample_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_y_s1 <= py;
			sq_z_s1 <= pz;
			item_s1 <= sample;
			sum_s2  <= sq_y_s1 + sq_z_s1;
			item_s2 <= item_s1;
		end
	end

	// ---- square root
	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	sample_t           sq_item;

	att_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s2),
		.radicand  ({sum_s2, 16'b0}),
		.side_in   (item_s2),
		.out_valid (sq_vld),
		.root      (sq_root),
		.side_out  (sq_item)
	);

	// ---- three CORDICs in lockstep
	logic                    roll_vld, pitch_vld, head_vld;
	logic signed [ANG_W-1:0] roll_ang, pitch_ang, head_ang;

	att_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (sq_vld),
		.num          (scale8(sq_item.accel_y)),
		.den          (scale8(sq_item.accel_z)),
		.heading_rule (1'b0),
		.out_valid    (roll_vld),
		.angle        (roll_ang)
	);

	att_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (sq_vld),
		.num          (-scale8(sq_item.accel_x)),
		.den          ($signed({1'b0, sq_root})),
		.heading_rule (1'b0),
		.out_valid    (pitch_vld),
		.angle        (pitch_ang)
	);

	att_cordic #(.STEPS(CORDIC_STEPS)) u_head (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (sq_vld),
		.num          (scale8(sq_item.mag_first)),
		.den          (scale8(sq_item.mag_second)),
		.heading_rule (1'b1),
		.out_valid    (head_vld),
		.angle        (head_ang)
	);

	// ---- pitch clamp, declination and wrap
	localparam logic signed [ANG_W-1:0] QUARTER = ANG_W'(QUARTER_TURN);
	localparam logic signed [17:0]      FULL18  = 18'(FULL_TURN);

	logic signed [17:0]      h_raw, h_wrap;
	logic signed [ANG_W-1:0] pitch_clip;
	attitude_t               out_q;

	assign h_raw = $signed({{2{head_ang[15]}}, head_ang}) - $signed({{2{decl_q[15]}}, decl_q});

	always_comb begin
		if (h_raw < -FULL18) begin
			h_wrap = h_raw + FULL18 + FULL18;
		end else if (h_raw < 18'sd0) begin
			h_wrap = h_raw + FULL18;
		end else if (h_raw >= FULL18) begin
			h_wrap = h_raw - FULL18;
		end else begin
			h_wrap = h_raw;
		end
		if (pitch_ang > QUARTER) begin
			pitch_clip = QUARTER;
		end else if (pitch_ang < -QUARTER) begin
			pitch_clip = -QUARTER;
		end else begin
			pitch_clip = pitch_ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= roll_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.pitch_centideg   <= pitch_clip[14:0];
			out_q.roll_centideg    <= roll_ang;
			out_q.heading_centideg <= h_wrap[15:0];
		end
	end

	assign attitude_valid = out_vld_q;
	assign attitude       = out_q;

`ifndef ASSERT_OFF
	a_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(roll_vld == pitch_vld) && (roll_vld == head_vld))
		else $error("CORDIC lanes out of step");
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		attitude_valid |-> (attitude.heading_centideg < 16'(FULL_TURN)))
		else $error("heading outside full turn");
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		attitude_valid |-> ($signed(attitude.pitch_centideg) <= 15'sd9000 &&
			$signed(attitude.pitch_centideg) >= -15'sd9000))
		else $error("pitch outside quarter turn");
	a_stall_backs_up: assert property (@(posedge clk) disable iff (!arst_n)
		(attitude_valid && !attitude_ready) |-> !sample_ready)
		else $error("input taken while output stalled");
`endif

endmodule

// File: bench/tb_attitude_from_accel_mag.sv
// ----------------------------------------------------------------------------
// tb_attitude_from_accel_mag
// Drives random and corner accel/mag samples through the attitude pipeline
// under bursty input and stalling output, predicts each result with a
// bit-exact CORDIC model and checks results in order; declination is
// rewritten between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_attitude_from_accel_mag;
	timeunit 1ns;
	timeprecision 1ps;
	import att_pkg::*;

	localparam int LATENCY   = CORDIC_STEPS_DEF + 29;
	localparam int CYC_LIMIT = 400000;

	class attitude_board;
		attitude_t pending[$];
		int errors;
		logic signed [15:0] decl;

		function longint fshr(longint v, int n);
			return v >>> n;
		endfunction

		function longint isqrt(longint v);
			longint res, b;
			res = 0;
			b = 64'sd1 <<< 62;
			while (b > v) b = b >>> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - res - b;
					res = (res >>> 1) + b;
				end else begin
					res = res >>> 1;
				end
				b = b >>> 2;
			end
			return res;
		endfunction

		function int atan2_cd(longint num, longint den);
			longint x, y, acc, dx, dy, r;
			if (num == 0) return (den < 0) ? HALF_TURN : 0;
			if (den == 0) return (num > 0) ? QUARTER_TURN : -QUARTER_TURN;
			x = den * 256;
			y = num * 256;
			acc = 0;
			if (x < 0) begin
				acc = (y >= 0) ? 18000 * 256 : -18000 * 256;
				x = -x;
				y = -y;
			end
			for (int i = 0; i < CORDIC_STEPS_DEF && i < TAB_LEN; i++) begin
				dx = fshr(y, i);
				dy = fshr(x, i);
				if (y >= 0) begin
					x += dx; y -= dy; acc += ATAN_TAB[i];
				end else begin
					x -= dx; y += dy; acc -= ATAN_TAB[i];
				end
			end
			r = fshr(acc + 128, 8);
			if (r > HALF_TURN) r = HALF_TURN;
			if (r < -HALF_TURN) r = -HALF_TURN;
			return int'(r);
		endfunction

		function void note_sample(sample_t s);
			longint ax, ay, az, mf, ms, den;
			int pitch, roll, head, h;
			attitude_t a;
			ax = s.accel_x; ay = s.accel_y; az = s.accel_z;
			mf = s.mag_first; ms = s.mag_second;
			roll = atan2_cd(ay * 256, az * 256);
			den = isqrt((ay * ay + az * az) * 65536);
			pitch = atan2_cd(-ax * 256, den);
			if (pitch > QUARTER_TURN) pitch = QUARTER_TURN;
			if (pitch < -QUARTER_TURN) pitch = -QUARTER_TURN;
			if (ms == 0) head = (mf < 0) ? HALF_TURN : 0;
			else head = atan2_cd(mf * 256, ms * 256);
			h = (head - int'(decl)) % FULL_TURN;
			if (h < 0) h += FULL_TURN;
			a.pitch_centideg = pitch[14:0];
			a.roll_centideg = roll[15:0];
			a.heading_centideg = h[15:0];
			pending.push_back(a);
		endfunction

		function void check_attitude(attitude_t got);
			attitude_t want;
			if (pending.size() == 0) begin
				report_err("result with nothing expected");
				return;
			end
			want = pending.pop_front();
			if (got.pitch_centideg !== want.pitch_centideg)
				report_err($sformatf("pitch got %0d want %0d",
					got.pitch_centideg, want.pitch_centideg));
			if (got.roll_centideg !== want.roll_centideg)
				report_err($sformatf("roll got %0d want %0d",
					got.roll_centideg, want.roll_centideg));
			if (got.heading_centideg !== want.heading_centideg)
				report_err($sformatf("heading got %0d want %0d",
					got.heading_centideg, want.heading_centideg));
		endfunction

		function void report_err(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic sample_valid = 0;
	logic sample_ready;
	sample_t sample = '0;
	logic attitude_valid;
	logic attitude_ready = 0;
	attitude_t attitude;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic signed [15:0] cfg_data = '0;

	attitude_board board;
	int cycles = 0;
	bit hold_off = 0;
	bit no_stall = 0;

	always #5 clk = ~clk;

	attitude_from_accel_mag u_dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
		.attitude_valid(attitude_valid), .attitude_ready(attitude_ready),
		.attitude(attitude),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: own stall pattern, long hold-off on request
	always @(posedge clk) begin
		if (attitude_valid && attitude_ready)
			board.check_attitude(attitude);
		if (hold_off) attitude_ready <= 0;
		else if (no_stall) attitude_ready <= 1;
		else attitude_ready <= ($urandom_range(0, 99) < 70);
	end

	task automatic send_sample(sample_t s);
		sample_valid <= 1;
		sample <= s;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		board.note_sample(s);
	endtask

	task automatic pause_input(int n);
		sample_valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic write_decl(logic signed [15:0] v);
		sample_valid <= 0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		board.decl = v;
	endtask

	function automatic logic [15:0] rnd_axis();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'($signed($urandom_range(0, 16)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic sample_t rnd_sample();
		sample_t s;
		s.accel_x = rnd_axis();
		s.accel_y = rnd_axis();
		s.accel_z = rnd_axis();
		s.mag_first = rnd_axis();
		s.mag_second = rnd_axis();
		return s;
	endfunction

	task automatic random_burst(int count);
		int left, burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 30);
			for (int i = 0; i < burst && left > 0; i++) begin
				send_sample(rnd_sample());
				left--;
			end
			if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 12));
		end
	endtask

	initial begin
		logic signed [15:0] corner[7];
		logic signed [15:0] decls[5];
		sample_t s;
		corner = '{16'sh8000, 16'sh7fff, 0, 1, -1, 100, -100};
		decls = '{16'sh8000, 16'sh7fff, 16'sd18000, -16'sd18000, 16'sd0};
		board = new();
		board.decl = DECL_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed corners at reset declination
		for (int i = 0; i < 22; i++) begin
			s.accel_x = corner[i % 7];
			s.accel_y = corner[(i / 7 + i) % 7];
			s.accel_z = corner[(i * 3) % 7];
			s.mag_first = corner[(i * 5 + 1) % 7];
			s.mag_second = corner[(i / 3) % 7];
			send_sample(s);
		end

		no_stall = 1;
		random_burst(150);
		no_stall = 0;

		// long receiver hold-off while input keeps coming
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			random_burst(200);
		join

		for (int p = 0; p < 5; p++) begin
			write_decl(decls[p]);
			random_burst(150);
		end
		write_decl(16'($signed($urandom_range(0, 36000)) - 18000));
		random_burst(400);

		sample_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (board.errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end
endmodule
